// File: rtl/core/tcge_pkg.sv
`timescale 1ns / 1ps

package tcge_pkg;

	// Glyph store geometry: five column bytes for each character.
	localparam int GLYPH_COUNT = 256;
	localparam int GLYPH_COLS  = 5;
	localparam int STORE_SIZE  = GLYPH_COUNT * GLYPH_COLS;
	localparam int GADDR_W     = $clog2(STORE_SIZE);

	// Register map, by word index on the configuration port.
	localparam int          PADDR_W              = 5;
	localparam logic [2:0]  REG_TEXT_SCALE       = 3'd0;
	localparam logic [2:0]  REG_CLEAR_ON_NEWLINE = 3'd1;
	localparam logic [2:0]  REG_WRAP_ENABLE      = 3'd2;
	localparam logic [2:0]  REG_FOREGROUND_COLOR = 3'd3;
	localparam logic [2:0]  REG_BACKGROUND_COLOR = 3'd4;
	localparam logic [2:0]  REG_SCREEN_WIDTH     = 3'd5;
	localparam logic [2:0]  REG_SCREEN_HEIGHT    = 3'd6;

	// Request codes.
	localparam logic [1:0] REQ_WRITE_CHAR = 2'd0;
	localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
	localparam logic [1:0] REQ_LOAD_GLYPH = 2'd2;

	// Control characters.
	localparam logic [7:0] CH_NEWLINE = 8'd10;
	localparam logic [7:0] CH_RETURN  = 8'd13;

	// Result kinds.
	localparam logic KIND_COLUMN = 1'b0;
	localparam logic KIND_CLEAR  = 1'b1;

	// Column index of the blank sixth column, the last beat of a character.
	localparam logic [2:0] COL_LAST = 3'd5;

	// One job in flight toward the output register.
	typedef struct packed {
		logic               kind;
		logic [2:0]         col;
		logic [15:0]        x;
		logic [15:0]        y;
		logic [15:0]        w;
		logic [6:0]         h;
		logic               ch_ok;
		logic               bgp;
		logic [GADDR_W-1:0] base;
	} job_t;

	// Scale register value clamped to the range 1 to 8.
	function automatic logic [3:0] eff_scale(input logic [3:0] s);
		logic [3:0] r;
		if (s == 4'd0) begin
			r = 4'd1;
		end else if (s > 4'd8) begin
			r = 4'd8;
		end else begin
			r = s;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/tcge_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module tcge_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1280,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/text_cursor_glyph_engine.sv
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// input     in_valid / in_stall      req_type, char_code, new_cursor_x/y, glyph_address, glyph_byte
// output    out_valid / out_stall    result_kind, pos_x, pos_y, rect_width, rect_height,
//                                    dot_bits, paint_background, last
// config    psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// A visible character yields one output beat for each of its five glyph columns and one
// for the blank sixth column, paced by the single glyph RAM read port and the output register.
// A new item is taken in the cycle the last beat of the current job moves out.
// Reset clears the cursor and all valid flags and sets the configuration registers to their
// defaults; the glyph store is not cleared and holds garbage until loaded.
// With out_valid high, out_stall freezes the output register, column sequencer and RAM read data.

module text_cursor_glyph_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [7:0]                     char_code,
	input  logic signed [15:0]             new_cursor_x,
	input  logic signed [15:0]             new_cursor_y,
	input  logic [10:0]                    glyph_address,
	input  logic [7:0]                     glyph_byte,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic signed [15:0]             pos_x,
	output logic signed [15:0]             pos_y,
	output logic signed [15:0]             rect_width,
	output logic [6:0]                     rect_height,
	output logic [7:0]                     dot_bits,
	output logic                           paint_background,
	output logic                           last,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [tcge_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	import tcge_pkg::*;

	// Configuration registers.
	logic [3:0]  scale_q;
	logic        clr_nl_q;
	logic        wrap_q;
	logic [15:0] fg_q;
	logic [15:0] bg_q;
	logic [9:0]  sw_q;
	logic [9:0]  sh_q;

	// Cursor.
	logic [15:0] cur_col_q;
	logic [15:0] cur_row_q;

	// Job stage and output register.
	logic        job_vld_s1;
	job_t        job_s1;
	logic        out_valid_q;
	logic        kind_q;
	logic [15:0] pos_x_q;
	logic [15:0] pos_y_q;
	logic [15:0] width_q;
	logic [6:0]  height_q;
	logic [7:0]  dots_q;
	logic        bgp_q;
	logic        last_q;

	logic [2:0]  reg_idx;
	logic        cfg_wr;
	logic [3:0]  eff_s;
	logic [6:0]  s8;
	logic [5:0]  s6;
	logic [17:0] x_ext;
	logic [17:0] y_ext;
	logic [17:0] sw_ext;
	logic [17:0] sh_ext;
	logic [17:0] x_right;
	logic [17:0] y_bottom;
	logic        visible;
	logic [15:0] col_adv;
	logic [17:0] wrap_lim;
	logic        wrap_hit;
	logic [15:0] row_nl;
	logic [10:0] base_full;
	logic        in_acc;
	logic        is_char;
	logic        is_nl;
	logic        is_cr;
	logic        start_col;
	logic        start_clr;
	logic        xfer;
	logic        beat_last;
	logic        glyph_we;
	logic        glyph_re;
	logic [GADDR_W-1:0] glyph_raddr;
	logic [GADDR_W-1:0] next_raddr;
	logic [7:0]  glyph_rdata;

	// Configuration port: always ready, word addressed.
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 4'd1;
			clr_nl_q <= 1'b0;
			wrap_q   <= 1'b0;
			fg_q     <= 16'd0;
			bg_q     <= 16'd0;
			sw_q     <= 10'd240;
			sh_q     <= 10'd320;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TEXT_SCALE:       scale_q  <= pwdata[3:0];
				REG_CLEAR_ON_NEWLINE: clr_nl_q <= pwdata[0];
				REG_WRAP_ENABLE:      wrap_q   <= pwdata[0];
				REG_FOREGROUND_COLOR: fg_q     <= pwdata[15:0];
				REG_BACKGROUND_COLOR: bg_q     <= pwdata[15:0];
				REG_SCREEN_WIDTH:     sw_q     <= pwdata[9:0];
				REG_SCREEN_HEIGHT:    sh_q     <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TEXT_SCALE:       prdata = {28'd0, scale_q};
			REG_CLEAR_ON_NEWLINE: prdata = {31'd0, clr_nl_q};
			REG_WRAP_ENABLE:      prdata = {31'd0, wrap_q};
			REG_FOREGROUND_COLOR: prdata = {16'd0, fg_q};
			REG_BACKGROUND_COLOR: prdata = {16'd0, bg_q};
			REG_SCREEN_WIDTH:     prdata = {22'd0, sw_q};
			REG_SCREEN_HEIGHT:    prdata = {22'd0, sh_q};
			default:              prdata = 32'd0;
		endcase
	end

	// Cell size from the clamped scale.
	assign eff_s = eff_scale(scale_q);
	assign s8    = {eff_s, 3'b000};
	assign s6    = {eff_s, 2'b00} + {1'b0, eff_s, 1'b0};

	// Visibility of the character cell at the current cursor.
	assign x_ext    = {{2{cur_col_q[15]}}, cur_col_q};
	assign y_ext    = {{2{cur_row_q[15]}}, cur_row_q};
	assign sw_ext   = {8'd0, sw_q};
	assign sh_ext   = {8'd0, sh_q};
	assign x_right  = x_ext + {12'd0, s6} - 18'd1;
	assign y_bottom = y_ext + {11'd0, s8} - 18'd1;
	assign visible  = !(($signed(x_ext) >= $signed(sw_ext)) ||
			    ($signed(y_ext) >= $signed(sh_ext)) ||
			    x_right[17] || y_bottom[17]);

	// Cursor advance, wrap test and line feed.
	assign col_adv  = cur_col_q + {10'd0, s6};
	assign wrap_lim = sw_ext - {12'd0, s6};
	assign wrap_hit = wrap_q && ($signed({{2{col_adv[15]}}, col_adv}) > $signed(wrap_lim));
	assign row_nl   = cur_row_q + {9'd0, s8};

	// Input decode.
	assign xfer      = job_vld_s1 && (!out_valid_q || !out_stall);
	assign beat_last = (job_s1.kind == KIND_CLEAR) || (job_s1.col == COL_LAST);
	assign in_stall  = job_vld_s1 && !(xfer && beat_last);
	assign in_acc    = in_valid && !in_stall;
	assign is_char   = (req_type == REQ_WRITE_CHAR);
	assign is_nl     = (char_code == CH_NEWLINE);
	assign is_cr     = (char_code == CH_RETURN);
	assign start_col = in_acc && is_char && !is_nl && !is_cr && visible;
	assign start_clr = in_acc && is_char && is_nl && clr_nl_q;
	assign base_full = {1'b0, char_code, 2'b00} + {3'd0, char_code};

	// Cursor update, in item order at acceptance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 16'd0;
			cur_row_q <= 16'd0;
		end else if (in_acc) begin
			case (req_type)
				REQ_SET_CURSOR: begin
					cur_col_q <= new_cursor_x;
					cur_row_q <= new_cursor_y;
				end
				REQ_WRITE_CHAR: begin
					if (is_nl || (!is_cr && wrap_hit)) begin
						cur_row_q <= row_nl;
						cur_col_q <= 16'd0;
					end else if (!is_cr) begin
						cur_col_q <= col_adv;
					end
				end
				default: ;
			endcase
		end
	end

	// Glyph RAM: loads write at acceptance, columns are read one beat ahead.
	assign glyph_we    = in_acc && (req_type == REQ_LOAD_GLYPH) &&
			     (glyph_address < 11'(STORE_SIZE));
	assign next_raddr  = job_s1.base + {{(GADDR_W-3){1'b0}}, job_s1.col} + GADDR_W'(1);
	assign glyph_re    = start_col ||
			     (xfer && (job_s1.kind == KIND_COLUMN) && (job_s1.col < 3'd4));
	assign glyph_raddr = start_col ? base_full[GADDR_W-1:0] : next_raddr;

	tcge_ram #(
		.WIDTH (8),
		.DEPTH (STORE_SIZE)
	) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (glyph_address[GADDR_W-1:0]),
		.wdata (glyph_byte),
		.re    (glyph_re),
		.raddr (glyph_raddr),
		.rdata (glyph_rdata)
	);

	// Job valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s1 <= 1'b0;
		end else if (start_col || start_clr) begin
			job_vld_s1 <= 1'b1;
		end else if (xfer && beat_last) begin
			job_vld_s1 <= 1'b0;
		end
	end

	// Job payload: loaded at start, stepped one column per beat.
	always_ff @(posedge clk) begin
		if (start_col) begin
			job_s1.kind  <= KIND_COLUMN;
			job_s1.col   <= 3'd0;
			job_s1.x     <= cur_col_q;
			job_s1.y     <= cur_row_q;
			job_s1.w     <= {12'd0, eff_s};
			job_s1.h     <= s8;
			job_s1.ch_ok <= ({1'b0, char_code} < 9'(GLYPH_COUNT));
			job_s1.bgp   <= (bg_q != fg_q);
			job_s1.base  <= base_full[GADDR_W-1:0];
		end else if (start_clr) begin
			job_s1.kind  <= KIND_CLEAR;
			job_s1.col   <= 3'd0;
			job_s1.x     <= cur_col_q;
			job_s1.y     <= cur_row_q;
			job_s1.w     <= {6'd0, sw_q} - cur_col_q;
			job_s1.h     <= s8;
			job_s1.ch_ok <= 1'b0;
			job_s1.bgp   <= 1'b1;
			job_s1.base  <= base_full[GADDR_W-1:0];
		end else if (xfer && !beat_last) begin
			job_s1.col <= job_s1.col + 3'd1;
			job_s1.x   <= job_s1.x + job_s1.w;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (xfer) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (xfer) begin
			kind_q   <= job_s1.kind;
			pos_x_q  <= job_s1.x;
			pos_y_q  <= job_s1.y;
			width_q  <= job_s1.w;
			height_q <= job_s1.h;
			dots_q   <= ((job_s1.kind == KIND_COLUMN) && (job_s1.col != COL_LAST) &&
				     job_s1.ch_ok) ? glyph_rdata : 8'd0;
			bgp_q    <= job_s1.bgp;
			last_q   <= beat_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = kind_q;
	assign pos_x            = pos_x_q;
	assign pos_y            = pos_y_q;
	assign rect_width       = width_q;
	assign rect_height      = height_q;
	assign dot_bits         = dots_q;
	assign paint_background = bgp_q;
	assign last             = last_q;

	// The column sequencer never runs past the blank column.
	assert property (@(posedge clk) disable iff (!arst_n)
		job_vld_s1 |-> (job_s1.col <= COL_LAST))
		else $error("column index past last column");

	// A glyph load never lands while a character still reads its glyph bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		glyph_we |-> !(job_vld_s1 && (job_s1.kind == KIND_COLUMN) &&
			       (job_s1.col < COL_LAST)))
		else $error("glyph load overlaps a character in progress");

	// A started character enters the job stage at its first column.
	assert property (@(posedge clk) disable iff (!arst_n)
		start_col |=> (job_vld_s1 && (job_s1.col == 3'd0)))
		else $error("character job not started at first column");

	// The last beat of a character is the blank column.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (result_kind == KIND_COLUMN) && last) |-> (dot_bits == 8'd0))
		else $error("blank column carries dots");

endmodule
